@@ sv/tga16_rle_packet_encoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// TGA RLE encoder assertion macros
// Concurrent checks with a clock, an active-low reset, an antecedent and
// a consequent. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TGA16_RLE_PACKET_ENCODER_TOP_ASSERT_SVH
`define TGA16_RLE_PACKET_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TGA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga rle check failed");

// next-cycle implication
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga rle check failed");

`else

`define TGA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/tga_rle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE encoder package
// Word types, packet modes, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    localparam int PIXEL_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int HDR_W    = 8;
    localparam int GROUP_W  = 64;
    localparam int GCOUNT_W = 3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [HDR_W-1:0] HDR_RUN_FLAG = 8'h80;

    typedef enum logic [1:0] {
        MODE_EMPTY  = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_RAW    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_HEADER = 2'd1,
        ST_GROUP  = 2'd2,
        ST_OUT    = 2'd3
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] pixel;
        logic               line_end;
    } t_in_word;

    typedef struct packed {
        logic                is_header;
        logic [HDR_W-1:0]    header_byte;
        logic [GROUP_W-1:0]  pixel_group;
        logic [GCOUNT_W-1:0] group_count;
        logic                last;
    } t_out_word;

endpackage

@@ sv/tga_rle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE stream interface
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface tga_rle_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tga_rle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tga_rle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/tga16_rle_packet_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA 16-bit RLE packet encoder
// Groups 16-bit pixels into type 10 run and raw packets.
// ----------------------------------------------------------------------------
// Input channel i_in: one word per pixel (cmd = 0) or a flush (cmd = 1).
// Output channel o_out: a header byte word, then pixel group words of up
// to four pixels each; last marks the final word caused by one input.
// A pixel that only grows the pending packet leaves the input ready, so
// such pixels stream one per cycle. A word that closes a packet holds off
// input while the packet drains: the header word first, then pixel group
// words of up to four pixels, filled one pixel at a time from the read
// port of the pixel store.
// Reset empties the encoder and clears the previous pixel to zero; the
// pixel store is not cleared and needs no clearing pass.
// A stalled receiver holds the output register; the sequencer waits on it
// and the input stays blocked until the packet has been handed off.
// ----------------------------------------------------------------------------
`include "tga16_rle_packet_encoder_top_assert.svh"

module tga16_rle_packet_encoder_top #(
    parameter int MAX_PACKET = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tga_rle_if.sink   i_in,
    tga_rle_if.source o_out
);

    localparam int AW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
    localparam logic [tga_rle_pkg::COUNT_W-1:0] LP_MAX =
        tga_rle_pkg::COUNT_W'(MAX_PACKET);

    tga_rle_pkg::t_state    r_state, n_state;
    tga_rle_pkg::t_mode     r_mode, n_mode;
    logic [tga_rle_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [tga_rle_pkg::PIXEL_W-1:0]  r_prev, n_prev;

    logic [tga_rle_pkg::COUNT_W-1:0]  r_len, r_rd_idx, r_cap_idx;
    logic [tga_rle_pkg::HDR_W-1:0]    r_hdr;
    logic                             r_wpend;
    logic [tga_rle_pkg::PIXEL_W-1:0]  r_pix;
    logic [tga_rle_pkg::GROUP_W-1:0]  r_grp;
    logic [tga_rle_pkg::GCOUNT_W-1:0] r_gcnt;
    logic                             r_dv;

    tga_rle_pkg::t_out_word r_out;
    logic                   r_out_vld;

    tga_rle_pkg::t_in_word w;
    logic acc, eq, full;
    logic [tga_rle_pkg::COUNT_W-1:0] cnt_m1, cnt_m2, n_cap;
    logic [tga_rle_pkg::HDR_W-1:0]   pend_hdr, a_hdr;
    logic [tga_rle_pkg::COUNT_W-1:0] pend_len, a_len;
    logic a_emit, a_wpend, a_wr_now;
    logic [AW-1:0] a_wr_addr;

    logic out_free, rd_en, cap, grp_done, ld_hdr, ld_grp, pkt_done, fin_wr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [tga_rle_pkg::PIXEL_W-1:0] wr_data, rd_data;

    assign w        = i_in.data;
    assign i_in.ready = (r_state == tga_rle_pkg::ST_IDLE);
    assign acc      = i_in.valid && i_in.ready;
    assign eq       = (w.pixel == r_prev);
    assign full     = (r_count >= LP_MAX);
    assign cnt_m1   = r_count - 8'd1;
    assign cnt_m2   = r_count - 8'd2;
    assign out_free = !r_out_vld || o_out.ready;
    assign n_cap    = r_cap_idx + 8'd1;
    assign pkt_done = (r_cap_idx == r_len);

    // pending packet as it would be emitted now
    always_comb begin
        case (r_mode)
            tga_rle_pkg::MODE_SINGLE: begin
                pend_hdr = '0;
                pend_len = 8'd1;
            end
            tga_rle_pkg::MODE_RUN: begin
                pend_hdr = tga_rle_pkg::HDR_RUN_FLAG | {1'b0, cnt_m1[6:0]};
                pend_len = 8'd1;
            end
            tga_rle_pkg::MODE_RAW: begin
                pend_hdr = {1'b0, cnt_m1[6:0]};
                pend_len = r_count;
            end
            default: begin
                pend_hdr = '0;
                pend_len = '0;
            end
        endcase
    end

    // packet decision for an accepted word
    always_comb begin
        a_emit    = 1'b0;
        a_hdr     = pend_hdr;
        a_len     = pend_len;
        a_wpend   = 1'b0;
        a_wr_now  = 1'b0;
        a_wr_addr = r_count[AW-1:0];
        n_mode    = r_mode;
        n_count   = r_count;
        n_prev    = r_prev;
        if (w.cmd == tga_rle_pkg::CMD_FLUSH) begin
            a_emit  = (r_mode != tga_rle_pkg::MODE_EMPTY);
            n_mode  = tga_rle_pkg::MODE_EMPTY;
            n_count = '0;
        end else begin
            n_prev = w.pixel;
            if (full) begin
                a_emit  = 1'b1;
                a_wpend = 1'b1;
                n_mode  = tga_rle_pkg::MODE_SINGLE;
                n_count = 8'd1;
            end else begin
                case (r_mode)
                    tga_rle_pkg::MODE_EMPTY: begin
                        a_wr_now  = 1'b1;
                        a_wr_addr = '0;
                        n_mode    = tga_rle_pkg::MODE_SINGLE;
                        n_count   = 8'd1;
                    end
                    tga_rle_pkg::MODE_SINGLE: begin
                        n_count = r_count + 8'd1;
                        if (eq) begin
                            n_mode = tga_rle_pkg::MODE_RUN;
                        end else begin
                            n_mode   = tga_rle_pkg::MODE_RAW;
                            a_wr_now = 1'b1;
                        end
                    end
                    tga_rle_pkg::MODE_RUN: begin
                        if (eq) begin
                            n_count = r_count + 8'd1;
                        end else begin
                            a_emit  = 1'b1;
                            a_wpend = 1'b1;
                            n_mode  = tga_rle_pkg::MODE_SINGLE;
                            n_count = 8'd1;
                        end
                    end
                    default: begin
                        if (eq) begin
                            // repeat closes the raw packet without its last pixel
                            a_emit  = 1'b1;
                            a_hdr   = {1'b0, cnt_m2[6:0]};
                            a_len   = cnt_m1;
                            a_wpend = 1'b1;
                            n_mode  = tga_rle_pkg::MODE_RUN;
                            n_count = 8'd2;
                        end else begin
                            a_wr_now = 1'b1;
                            n_count  = r_count + 8'd1;
                        end
                    end
                endcase
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tga_rle_pkg::ST_IDLE: begin
                if (acc && a_emit) n_state = tga_rle_pkg::ST_HEADER;
            end
            tga_rle_pkg::ST_HEADER: begin
                if (out_free) n_state = tga_rle_pkg::ST_GROUP;
            end
            tga_rle_pkg::ST_GROUP: begin
                if (grp_done) n_state = tga_rle_pkg::ST_OUT;
            end
            tga_rle_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = pkt_done ? tga_rle_pkg::ST_IDLE : tga_rle_pkg::ST_GROUP;
                end
            end
            default: n_state = tga_rle_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        rd_en    = 1'b0;
        cap      = 1'b0;
        grp_done = 1'b0;
        ld_hdr   = 1'b0;
        ld_grp   = 1'b0;
        fin_wr   = 1'b0;
        case (r_state)
            tga_rle_pkg::ST_HEADER: begin
                ld_hdr = out_free;
            end
            tga_rle_pkg::ST_GROUP: begin
                rd_en    = (r_rd_idx < r_len) && (r_rd_idx[7:2] == r_cap_idx[7:2]);
                cap      = r_dv;
                grp_done = r_dv && ((n_cap == r_len) || (n_cap[1:0] == 2'b00));
            end
            tga_rle_pkg::ST_OUT: begin
                ld_grp = out_free;
                fin_wr = out_free && pkt_done && r_wpend;
            end
            default: ;
        endcase
    end

    assign wr_en   = (acc && a_wr_now) || fin_wr;
    assign wr_addr = fin_wr ? '0 : a_wr_addr;
    assign wr_data = fin_wr ? r_pix : w.pixel;

    tga_rle_ram #(
        .WIDTH (tga_rle_pkg::PIXEL_W),
        .DEPTH (MAX_PACKET)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tga_rle_pkg::ST_IDLE;
            r_mode    <= tga_rle_pkg::MODE_EMPTY;
            r_count   <= '0;
            r_prev    <= '0;
            r_out_vld <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en;
            if (acc) begin
                r_mode  <= n_mode;
                r_count <= n_count;
                r_prev  <= n_prev;
            end
            if (ld_hdr || ld_grp) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && a_emit) begin
            r_hdr     <= a_hdr;
            r_len     <= a_len;
            r_wpend   <= a_wpend;
            r_pix     <= w.pixel;
            r_rd_idx  <= '0;
            r_cap_idx <= '0;
            r_grp     <= '0;
        end
        if (rd_en) begin
            r_rd_idx <= r_rd_idx + 8'd1;
        end
        if (cap) begin
            r_grp[r_cap_idx[1:0]*tga_rle_pkg::PIXEL_W +: tga_rle_pkg::PIXEL_W] <= rd_data;
            r_cap_idx <= n_cap;
            r_gcnt    <= {1'b0, r_cap_idx[1:0]} + 3'd1;
        end
        if (ld_hdr) begin
            r_out.is_header   <= 1'b1;
            r_out.header_byte <= r_hdr;
            r_out.pixel_group <= '0;
            r_out.group_count <= '0;
            r_out.last        <= 1'b0;
        end else if (ld_grp) begin
            r_out.is_header   <= 1'b0;
            r_out.header_byte <= '0;
            r_out.pixel_group <= r_grp;
            r_out.group_count <= r_gcnt;
            r_out.last        <= pkt_done;
            r_grp             <= '0;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    `TGA_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= LP_MAX)
    `TGA_ASSERT_NOW(a_mode_count, i_clk, i_rst_n, 1'b1, (r_mode == tga_rle_pkg::MODE_EMPTY) == (r_count == '0))
    `TGA_ASSERT_NOW(a_rd_bound, i_clk, i_rst_n, rd_en, r_rd_idx < r_len)
    `TGA_ASSERT_NOW(a_grp_count, i_clk, i_rst_n, r_out_vld && !r_out.is_header, r_out.group_count != '0)
    `TGA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, ld_grp && pkt_done, r_state == tga_rle_pkg::ST_IDLE && r_out.last)

endmodule
